// File: rtl/core/delta_copy_address_cache_macros.svh
// Assertion macros for the copy address cache.
`ifndef DELTA_COPY_ADDRESS_CACHE_MACROS_SVH
`define DELTA_COPY_ADDRESS_CACHE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, off while reset is low.
`define DCAC_ASSERT_IMP(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is low.
`define DCAC_ASSERT_NXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define DCAC_ASSERT_NXT_ALWAYS(lbl, c, ante, cons, msg) \
  lbl: assert property (@(posedge c) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DCAC_ASSERT_IMP(lbl, c, r, ante, cons, msg)
`define DCAC_ASSERT_NXT(lbl, c, r, ante, cons, msg)
`define DCAC_ASSERT_NXT_ALWAYS(lbl, c, ante, cons, msg)

`endif

`endif

// File: rtl/core/dcac_pkg.sv
package dcac_pkg;

  localparam int NEAR_SLOTS_DEF  = 8;
  localparam int SAME_BLOCKS_DEF = 4;

  localparam int BLOCK_ENTRIES = 256;
  localparam int BLOCK_SHIFT   = 8;

  localparam int WORD_W     = 32;
  localparam int MODE_W     = 4;
  localparam int NEAR_CFG_W = 4;
  localparam int SAME_CFG_W = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [MODE_W-1:0] MODE_SELF       = 4'd0;
  localparam logic [MODE_W-1:0] MODE_HERE       = 4'd1;
  localparam logic [MODE_W-1:0] FIRST_NEAR_MODE = 4'd2;

  localparam logic [NEAR_CFG_W-1:0] NEAR_SIZE_RST = 4'd4;
  localparam logic [SAME_CFG_W-1:0] SAME_SIZE_RST = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_SIZE = 1'b0,
    CFG_SAME_SIZE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_MUL_Q,
    ST_MUL_QS,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic decode;
    logic mul_q;
    logic mul_qs;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/core/dcac_ram.sv
module dcac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/dcac_ctrl.sv
module dcac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  dcac_pkg::sts_t    sts,
  output dcac_pkg::cmd_t    cmd
);

  dcac_pkg::state_t state_r;
  dcac_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dcac_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      dcac_pkg::ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = dcac_pkg::ST_IDLE;
        end
      end
      dcac_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = dcac_pkg::ST_ADDR;
        end
      end
      dcac_pkg::ST_ADDR: begin
        cmd.decode = 1'b1;
        state_nxt  = dcac_pkg::ST_MUL_Q;
      end
      dcac_pkg::ST_MUL_Q: begin
        cmd.mul_q = 1'b1;
        state_nxt = dcac_pkg::ST_MUL_QS;
      end
      dcac_pkg::ST_MUL_QS: begin
        cmd.mul_qs = 1'b1;
        state_nxt  = dcac_pkg::ST_COMMIT;
      end
      dcac_pkg::ST_COMMIT: begin
        // hold until the output register can take the result
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = dcac_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dcac_pkg::ST_CLEAR;
      end
    endcase
  end

endmodule

// File: rtl/core/dcac_dp.sv
module dcac_dp #(
  parameter int NEAR_SLOTS  = dcac_pkg::NEAR_SLOTS_DEF,
  parameter int SAME_BLOCKS = dcac_pkg::SAME_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dcac_pkg::cmd_t                  cmd,
  output dcac_pkg::sts_t                  sts,
  input  logic                            cfg_valid,
  input  logic [dcac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcac_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [dcac_pkg::MODE_W-1:0]     in_mode,
  input  logic [dcac_pkg::WORD_W-1:0]     in_operand,
  input  logic [dcac_pkg::WORD_W-1:0]     in_position,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dcac_pkg::WORD_W-1:0]     out_address,
  output logic                            out_bad
);

  localparam int DEPTH = SAME_BLOCKS * dcac_pkg::BLOCK_ENTRIES;
  localparam int TA_W  = $clog2(DEPTH);
  localparam int RI_W  = (NEAR_SLOTS > 1) ? $clog2(NEAR_SLOTS) : 1;
  localparam int ST_MAX = (SAME_BLOCKS < 7) ? SAME_BLOCKS : 7;
  localparam int W     = dcac_pkg::WORD_W;
  localparam int Q_W   = W - dcac_pkg::BLOCK_SHIFT;
  localparam int P_W   = Q_W + W;

  logic [dcac_pkg::NEAR_CFG_W-1:0] near_size_r;
  logic [dcac_pkg::SAME_CFG_W-1:0] same_size_r;
  logic [7:0] n8;
  logic [7:0] s8;

  logic [dcac_pkg::MODE_W-1:0] mode_r;
  logic [W-1:0]   op_r;
  logic [W-1:0]   pos_r;
  logic [W-1:0]   addr_r;
  logic [W-1:0]   addr_nxt;
  logic           bad_r;
  logic           bad_nxt;
  logic [W-1:0]   rcp_r;
  logic [W-1:0]   rcp_sel;
  logic [P_W-1:0] prod_r;
  logic [Q_W-1:0] qs_r;
  logic [Q_W-1:0] rem;

  logic [W-1:0]    ring_r [NEAR_SLOTS];
  logic [W-1:0]    ring_sel;
  logic [RI_W-1:0] ptr_r;
  logic [RI_W-1:0] ptr_nxt;
  logic [7:0]      p8;
  logic [7:0]      pn8;

  logic [7:0] mode8;
  logic [7:0] near_off;
  logic [7:0] same_off;
  logic [7:0] in_off;

  logic [TA_W-1:0] clr_cnt_r;
  logic [TA_W-1:0] rd_addr;
  logic [TA_W-1:0] wr_idx;
  logic [TA_W-1:0] ram_waddr;
  logic [W-1:0]    ram_wdata;
  logic [W-1:0]    ram_rdata;
  logic            ram_we;
  logic            do_write;

  logic [W-1:0] rcp_tab [ST_MAX+1];

  logic           out_valid_r;
  logic [W-1:0]   out_addr_r;
  logic           out_bad_r;

  // reciprocals ceil(2^32 / s) for the block count modulo
  for (genvar g = 0; g <= ST_MAX; g++) begin : g_rcp
    if (g < 2) begin : g_none
      assign rcp_tab[g] = '0;
    end else begin : g_val
      localparam logic [W:0] RCP_FULL = (33'h1_0000_0000 + 33'(g) - 33'd1) / 33'(g);
      assign rcp_tab[g] = RCP_FULL[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_size_r <= dcac_pkg::NEAR_SIZE_RST;
      same_size_r <= dcac_pkg::SAME_SIZE_RST;
    end else if (cfg_valid) begin
      unique case (dcac_pkg::cfg_reg_t'(cfg_index))
        dcac_pkg::CFG_NEAR_SIZE: near_size_r <= cfg_data[dcac_pkg::NEAR_CFG_W-1:0];
        dcac_pkg::CFG_SAME_SIZE: same_size_r <= cfg_data[dcac_pkg::SAME_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign n8 = (8'(near_size_r) > 8'(NEAR_SLOTS)) ? 8'(NEAR_SLOTS) : 8'(near_size_r);
  assign s8 = (8'(same_size_r) > 8'(SAME_BLOCKS)) ? 8'(SAME_BLOCKS) : 8'(same_size_r);

  // issue the same table read from the incoming item so data is ready after accept
  assign in_off  = 8'(in_mode) - 8'(dcac_pkg::FIRST_NEAR_MODE) - n8;
  assign rd_addr = TA_W'({in_off, in_operand[7:0]});

  assign mode8    = 8'(mode_r);
  assign near_off = mode8 - 8'(dcac_pkg::FIRST_NEAR_MODE);
  assign same_off = near_off - n8;

  always_comb begin
    ring_sel = '0;
    for (int i = 0; i < NEAR_SLOTS; i++) begin
      if (near_off == 8'(i)) begin
        ring_sel = ring_r[i];
      end
    end
  end

  always_comb begin
    rcp_sel = '0;
    for (int i = 0; i <= ST_MAX; i++) begin
      if (s8 == 8'(i)) begin
        rcp_sel = rcp_tab[i];
      end
    end
  end

  always_comb begin
    addr_nxt = '0;
    bad_nxt  = 1'b0;
    if (mode_r == dcac_pkg::MODE_SELF) begin
      addr_nxt = op_r;
    end else if (mode_r == dcac_pkg::MODE_HERE) begin
      addr_nxt = pos_r - op_r;
    end else if (near_off < n8) begin
      addr_nxt = ring_sel + op_r;
    end else if (same_off < s8) begin
      addr_nxt = ram_rdata;
    end else begin
      bad_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      op_r   <= in_operand;
      pos_r  <= in_position;
    end
    if (cmd.decode) begin
      addr_r <= addr_nxt;
      bad_r  <= bad_nxt;
      rcp_r  <= rcp_sel;
    end
    if (cmd.mul_q) begin
      prod_r <= P_W'(addr_r[W-1:dcac_pkg::BLOCK_SHIFT]) * P_W'(rcp_r);
    end
    if (cmd.mul_qs) begin
      qs_r <= prod_r[P_W-1:W] * Q_W'(s8);
    end
  end

  // remainder of the block number; one block means the low byte alone
  assign rem    = addr_r[W-1:dcac_pkg::BLOCK_SHIFT] - qs_r;
  assign wr_idx = (s8 == 8'd1) ? TA_W'({8'd0, addr_r[7:0]})
                               : TA_W'({rem[7:0], addr_r[7:0]});

  assign p8      = (8'(ptr_r) < n8) ? 8'(ptr_r) : 8'd0;
  assign pn8     = p8 + 8'd1;
  assign ptr_nxt = (pn8 == n8) ? '0 : RI_W'(pn8);

  assign do_write = cmd.commit && !bad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
      for (int i = 0; i < NEAR_SLOTS; i++) begin
        ring_r[i] <= '0;
      end
    end else if (do_write && (n8 != 8'd0)) begin
      ptr_r <= ptr_nxt;
      for (int i = 0; i < NEAR_SLOTS; i++) begin
        if (p8 == 8'(i)) begin
          ring_r[i] <= addr_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + TA_W'(1);
    end
  end

  assign sts.clear_last = (clr_cnt_r == TA_W'(DEPTH - 1));

  assign ram_we    = cmd.clear || (do_write && (s8 != 8'd0));
  assign ram_waddr = cmd.clear ? clr_cnt_r : wr_idx;
  assign ram_wdata = cmd.clear ? '0 : addr_r;

  dcac_ram #(
    .WIDTH (W),
    .DEPTH (DEPTH)
  ) u_same_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_addr_r <= addr_r;
      out_bad_r  <= bad_r;
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid  = out_valid_r;
  assign out_address = out_addr_r;
  assign out_bad     = out_bad_r;

endmodule

// File: rtl/core/delta_copy_address_cache.sv
// An item that transfers in passes through decode (ADDR), the two-step multiply modulo
//   unit (MUL_Q, MUL_QS) and COMMIT, which writes its result to the output register and
//   raises out_tvalid. Only one item is in work at a time; a stalled output holds the commit step.
// Reset: synchronous, active low; afterwards the same table is cleared one entry
//   per cycle (SAME_BLOCKS*256 entries, 1024 by default) before in_tready rises.
// Configuration writes are taken at any time, including during the clear.
`include "delta_copy_address_cache_macros.svh"

module delta_copy_address_cache #(
  parameter int NEAR_SLOTS  = dcac_pkg::NEAR_SLOTS_DEF,
  parameter int SAME_BLOCKS = dcac_pkg::SAME_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [63:0]                     in_tdata,  // [31:0] operand, [63:32] position
  input  logic [dcac_pkg::MODE_W-1:0]     in_tuser,  // [3:0] address_mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [31:0]                     out_tdata, // [31:0] address
  output logic [0:0]                      out_tuser, // [0] bad_mode
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dcac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcac_pkg::CFG_DATA_W-1:0] cfg_data
);

  dcac_pkg::cmd_t cmd;
  dcac_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  dcac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dcac_dp #(
    .NEAR_SLOTS  (NEAR_SLOTS),
    .SAME_BLOCKS (SAME_BLOCKS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mode     (in_tuser),
    .in_operand  (in_tdata[31:0]),
    .in_position (in_tdata[63:32]),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_address (out_tdata),
    .out_bad     (out_tuser[0])
  );

  `DCAC_ASSERT_NXT(a_one_item_at_a_time, clk, rst_n, in_tvalid && in_tready, !in_tready, "input taken while an item is in work")
  `DCAC_ASSERT_IMP(a_bad_mode_zero_address, clk, rst_n, out_tvalid && out_tuser[0], out_tdata == 32'd0, "bad mode result with nonzero address")
  `DCAC_ASSERT_NXT_ALWAYS(a_clear_blocks_input, clk, !rst_n, !in_tready, "input ready right after reset")

endmodule

// File: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dcac_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int ITEMS_PER_PHASE = 128;
  localparam int NUM_PHASES = 9;
  localparam int SETTLE_CYCLES = 8;
  // Covers the table clear after reset and the longest random stall.
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [31:0] address;
    logic        bad_mode;
  } copy_result_t;

  class copy_address_predictor;
    bit [31:0] ring [NEAR_SLOTS_DEF];
    bit [31:0] same_tbl [SAME_BLOCKS_DEF*BLOCK_ENTRIES];
    int unsigned ring_ptr;
    bit [3:0] near_cfg;
    bit [2:0] same_cfg;
    copy_result_t pending_addrs[$];
    bit [31:0] recent_addrs[$];

    function new();
      foreach (ring[i]) ring[i] = '0;
      foreach (same_tbl[i]) same_tbl[i] = '0;
      ring_ptr = 0;
      near_cfg = NEAR_SIZE_RST;
      same_cfg = SAME_SIZE_RST;
    endfunction

    function int unsigned near_used();
      return (near_cfg > NEAR_SLOTS_DEF) ? NEAR_SLOTS_DEF : near_cfg;
    endfunction

    function int unsigned same_used();
      return (same_cfg > SAME_BLOCKS_DEF) ? SAME_BLOCKS_DEF : same_cfg;
    endfunction

    function void set_register(cfg_reg_t idx, bit [3:0] value);
      if (idx == CFG_NEAR_SIZE) near_cfg = value;
      else same_cfg = value[2:0];
    endfunction

    // Pick the same mode and low byte that read back addr from the table.
    function void same_hit(bit [31:0] addr, output bit [3:0] mode, output bit [7:0] low);
      int unsigned idx;
      idx = addr % (same_used() * BLOCK_ENTRIES);
      mode = 4'(FIRST_NEAR_MODE + near_used() + idx / BLOCK_ENTRIES);
      low = idx[7:0];
    endfunction

    function void note_copy(bit [3:0] mode, bit [31:0] operand, bit [31:0] position);
      int unsigned n, s, m, p;
      bit [31:0] addr;
      copy_result_t r;
      n = near_used();
      s = same_used();
      m = 32'(mode);
      r.bad_mode = 1'b0;
      addr = '0;
      if (mode == MODE_SELF) addr = operand;
      else if (mode == MODE_HERE) addr = position - operand;
      else if (m - FIRST_NEAR_MODE < n) addr = ring[m - FIRST_NEAR_MODE] + operand;
      else if (m - FIRST_NEAR_MODE - n < s)
        addr = same_tbl[(m - FIRST_NEAR_MODE - n) * BLOCK_ENTRIES + operand[7:0]];
      else r.bad_mode = 1'b1;
      if (!r.bad_mode) begin
        if (n > 0) begin
          // a pointer left beyond a shrunken ring restarts at slot 0
          p = (ring_ptr < n) ? ring_ptr : 0;
          ring[p] = addr;
          ring_ptr = (p + 1) % n;
        end
        if (s > 0) same_tbl[addr % (s * BLOCK_ENTRIES)] = addr;
        recent_addrs = {recent_addrs, addr};
        if (recent_addrs.size() > 16) void'(recent_addrs.pop_front());
      end
      r.address = addr;
      pending_addrs = {pending_addrs, r};
    endfunction

    function string check_address(logic [31:0] address, logic bad_mode);
      copy_result_t exp_r;
      string msg;
      if (pending_addrs.size() == 0)
        return $sformatf("result with no pending copy: address %h bad_mode %b",
                         address, bad_mode);
      exp_r = pending_addrs.pop_front();
      msg = "";
      if (address !== exp_r.address)
        msg = $sformatf("address %h, expected %h", address, exp_r.address);
      if (bad_mode !== exp_r.bad_mode)
        msg = {msg, $sformatf(" bad_mode %b, expected %b", bad_mode, exp_r.bad_mode)};
      return msg;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [63:0] in_tdata;
  logic [MODE_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [31:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  copy_address_predictor pred;
  int mismatches;
  int idle_cycles;
  int send_idle_pct;
  int recv_stall_pct;

  int phase_near [NUM_PHASES] = '{8, 1, 0, 15, 3, 8, 0, 2, 5};
  int phase_same [NUM_PHASES] = '{4, 1, 0, 7, 2, 0, 4, 1, 3};

  delta_copy_address_cache u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Start at a falling edge; return at the falling edge after the transfer.
  task send_copy(input logic [3:0] mode, input logic [31:0] operand,
                 input logic [31:0] position);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {position, operand};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task write_cache_reg(input cfg_reg_t idx, input logic [3:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task drain;
    while (pred.pending_addrs.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n && cfg_valid && cfg_ready)
      pred.set_register(cfg_reg_t'(cfg_index), cfg_data);
    if (rst_n && in_tvalid && in_tready)
      pred.note_copy(in_tuser, in_tdata[31:0], in_tdata[63:32]);
    if (rst_n && out_tvalid && out_tready) begin
      msg = pred.check_address(out_tdata, out_tuser[0]);
      if (msg != "") report_mismatch(msg);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [3:0] mode;
    logic [31:0] operand;
    logic [31:0] position;
    logic [7:0] low;
    int unsigned n, s, pick;

    pred = new();
    mismatches = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NEAR_SIZE;
    cfg_data = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset sizes: four near slots, three same blocks.
    send_copy(MODE_SELF, 32'h0000_0000, 32'h0000_0000);
    send_copy(MODE_SELF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_copy(MODE_HERE, 32'h0000_0001, 32'h0000_0000);
    send_copy(MODE_HERE, 32'h0000_0000, 32'hFFFF_FFFF);
    send_copy(MODE_HERE, 32'hFFFF_FFFF, 32'h0000_1000);
    send_copy(FIRST_NEAR_MODE, 32'h0000_0005, 32'h0);
    send_copy(FIRST_NEAR_MODE + 4'd3, 32'hFFFF_FFFF, 32'h0);
    send_copy(FIRST_NEAR_MODE + 4'd1, 32'h8000_0000, 32'h0);
    send_copy(FIRST_NEAR_MODE + 4'd4, 32'h0000_00FF, 32'h0);
    send_copy(FIRST_NEAR_MODE + 4'd6, 32'hABCD_EF01, 32'h0);
    send_copy(FIRST_NEAR_MODE + 4'd7, 32'h0, 32'h0);
    send_copy(4'd15, 32'h1234_5678, 32'h9ABC_DEF0);
    send_copy(MODE_SELF, 32'h0001_2345, 32'h0);
    pred.same_hit(32'h0001_2345, mode, low);
    send_copy(mode, {24'hFFFFFF, low}, 32'h0);
    send_copy(MODE_SELF, 32'h0000_02FF, 32'h0);
    pred.same_hit(32'h0000_02FF, mode, low);
    send_copy(mode, {24'h0, low}, 32'hFFFF_FFFF);
    send_copy(FIRST_NEAR_MODE, 32'h0, 32'h0);
    send_copy(FIRST_NEAR_MODE + 4'd2, 32'h7FFF_FFFF, 32'h0);
    send_copy(FIRST_NEAR_MODE + 4'd5, 32'h0, 32'h0);
    in_tvalid <= 1'b0;
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_cache_reg(CFG_NEAR_SIZE, 4'(phase_near[ph]));
      write_cache_reg(CFG_SAME_SIZE, 4'(phase_same[ph]));
      cfg_valid <= 1'b0;
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        n = pred.near_used();
        s = pred.same_used();
        pick = $urandom_range(99);
        operand = $urandom;
        position = $urandom;
        if (pick < 12) begin
          mode = MODE_SELF;
        end else if (pick < 24) begin
          mode = MODE_HERE;
        end else if (pick < 50 && n > 0) begin
          mode = 4'(FIRST_NEAR_MODE + $urandom_range(n - 1));
        end else if (pick < 85 && s > 0 && pred.recent_addrs.size() > 0) begin
          // read back an address decoded a few items ago
          pred.same_hit(pred.recent_addrs[$urandom_range(pred.recent_addrs.size() - 1)],
                        mode, low);
          operand[7:0] = low;
        end else begin
          mode = 4'($urandom_range(15));
        end
        send_copy(mode, operand, position);
      end
      in_tvalid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
    end

    if (mismatches == 0 && pred.pending_addrs.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
